FILE: rtl/itda_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the integer to decimal ASCII converter.
// No dependencies; used by the controller, the datapath and the top level.
package itda_pkg;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  width_code;
    logic        is_signed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic emit_sign;
    logic emit_digit;
    logic skip_digit;
  } itda_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic in_negative;
    logic started;
    logic digit_zero;
    logic pos_zero;
  } itda_status_t;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;
  localparam logic [1:0] WIDTH_64 = 2'd3;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [3:0] RADIX       = 4'd10;

  // Power of ten for one decimal place, places 0 to 19.
  function automatic logic [63:0] pow10(input logic [4:0] p);
    logic [63:0] r;
    case (p)
      5'd0:    r = 64'd1;
      5'd1:    r = 64'd10;
      5'd2:    r = 64'd100;
      5'd3:    r = 64'd1000;
      5'd4:    r = 64'd10000;
      5'd5:    r = 64'd100000;
      5'd6:    r = 64'd1000000;
      5'd7:    r = 64'd10000000;
      5'd8:    r = 64'd100000000;
      5'd9:    r = 64'd1000000000;
      5'd10:   r = 64'd10000000000;
      5'd11:   r = 64'd100000000000;
      5'd12:   r = 64'd1000000000000;
      5'd13:   r = 64'd10000000000000;
      5'd14:   r = 64'd100000000000000;
      5'd15:   r = 64'd1000000000000000;
      5'd16:   r = 64'd10000000000000000;
      5'd17:   r = 64'd100000000000000000;
      5'd18:   r = 64'd1000000000000000000;
      5'd19:   r = 64'd10000000000000000000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/integer_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Integer to decimal ASCII converter. Accepts one integer with a width code
// (8/16/32/64 bits, clamped to VALUE_BITS) and a signed flag, and sends its
// decimal text one character per beat, most significant digit first, with a
// leading '-' for negative signed values and last set on the final character.
// Each decimal place is resolved by comparing the magnitude with the nine
// multiples of that place's power of ten; the place counter always starts at
// the top place of a VALUE_BITS operand (20 places at 64 bits) and leading
// zeros are dropped one per cycle. An item is loaded, then a minus sign is
// sent if it is negative, then one digit beat per remaining place; the next
// item is accepted in the cycle after the last character enters the output
// register. Depends on itda_pkg, itda_ctrl and itda_datapath.
module integer_to_decimal_ascii #(
  parameter int VALUE_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  itda_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itda_pkg::out_item_t out_data
);

  itda_pkg::itda_cmd_t    cmd;
  itda_pkg::itda_status_t status;

  itda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  itda_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

FILE: rtl/itda_datapath.sv
`timescale 1ns / 1ps
// Datapath: operand masking and sign handling, the magnitude register, the
// decimal place counter, the digit step and the output beat register. Uses itda_pkg.
module itda_datapath #(
  parameter int VALUE_BITS = 64
) (
  input  logic                   clk,
  input  itda_pkg::in_item_t     in_data,
  input  itda_pkg::itda_cmd_t    cmd,
  output itda_pkg::itda_status_t status,
  output itda_pkg::out_item_t    out_data
);

  // Decimal places needed for the widest operand: floor(n * log10(2)) + 1.
  localparam int NumDigits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int PosW      = $clog2(NumDigits);
  localparam int ThrW      = VALUE_BITS + 4;

  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] mag_next;
  logic [PosW-1:0]       pos;
  logic                  started;
  logic [7:0]            character;
  logic                  last;

  // Operand preparation.
  logic [6:0]            sel_bits;
  logic [6:0]            eff_bits;
  logic [VALUE_BITS-1:0] keep;
  logic [VALUE_BITS-1:0] top;
  logic [VALUE_BITS-1:0] masked;
  logic [VALUE_BITS-1:0] load_mag;
  logic                  negative;

  always_comb begin
    case (in_data.width_code)
      itda_pkg::WIDTH_8:  sel_bits = 7'd8;
      itda_pkg::WIDTH_16: sel_bits = 7'd16;
      itda_pkg::WIDTH_32: sel_bits = 7'd32;
      itda_pkg::WIDTH_64: sel_bits = 7'd64;
      default:            sel_bits = 7'd64;
    endcase
    // Clamp the width to what the datapath holds.
    if (int'(sel_bits) > VALUE_BITS) begin
      eff_bits = 7'(VALUE_BITS);
    end else begin
      eff_bits = sel_bits;
    end
    for (int i = 0; i < VALUE_BITS; i++) begin
      keep[i] = (i < int'(eff_bits));
      top[i]  = (i + 1 == int'(eff_bits));
    end
    masked   = in_data.value[VALUE_BITS-1:0] & keep;
    negative = in_data.is_signed && (|(masked & top));
    load_mag = negative ? ((~masked + 1'b1) & keep) : masked;
  end

  // Digit step: find the largest k with k * 10^pos <= mag.
  logic [ThrW-1:0] p10;
  logic [ThrW-1:0] thresh [10];
  logic [3:0]      digit;

  assign p10 = ThrW'(itda_pkg::pow10(5'(pos)));

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      thresh[k] = p10 * ThrW'(k);
    end
    digit = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (ThrW'(mag) >= thresh[k]) begin
        digit = 4'(k);
      end
    end
    mag_next = mag - VALUE_BITS'(thresh[digit]);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag     <= load_mag;
      pos     <= PosW'(NumDigits - 1);
      started <= 1'b0;
    end else if (cmd.skip_digit) begin
      pos <= pos - 1'b1;
    end else if (cmd.emit_digit) begin
      mag     <= mag_next;
      pos     <= pos - 1'b1;
      started <= 1'b1;
    end
    if (cmd.emit_sign) begin
      character <= itda_pkg::ASCII_MINUS;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= itda_pkg::ASCII_ZERO + {4'd0, digit};
      last      <= (pos == '0);
    end
  end

  assign status.in_negative = negative;
  assign status.started     = started;
  assign status.digit_zero  = (digit == 4'd0);
  assign status.pos_zero    = (pos == '0);

  assign out_data.character = character;
  assign out_data.last      = last;

endmodule

FILE: rtl/itda_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences sign, leading zero skip and digit beats, and owns
// the input stall and the output valid. Uses itda_pkg.
module itda_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  itda_pkg::itda_status_t status,
  output itda_pkg::itda_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SIGN  = 2'd1;
  localparam logic [1:0] S_DIGIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_negative ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        // Drop leading zeros without using the output slot.
        if (!status.started && status.digit_zero && !status.pos_zero) begin
          cmd.skip_digit = 1'b1;
        end else if (out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.pos_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    out_valid_next = (out_valid && out_stall) || cmd.emit_sign || cmd.emit_digit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid || !out_stall))
    else $error("beat written over a held output");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state != S_IDLE))
    else $error("accepted item not converted");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit && status.pos_zero) |=> (state == S_IDLE && out_valid))
    else $error("final digit did not end the item");

  assert property (@(posedge clk) disable iff (rst)
    cmd.skip_digit |-> !status.started)
    else $error("zero dropped after first digit");

endmodule

FILE: test/integer_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for integer_to_decimal_ascii: a local decimal formatter predicts the
// text of every accepted number and each output beat is checked in order.
// Depends on itda_pkg and the integer_to_decimal_ascii RTL.
module integer_to_decimal_ascii_tb;

  localparam int VALUE_BITS = 64;
  localparam int MAX_CHARS  = 20;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  itda_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  itda_pkg::out_item_t out_data;

  itda_pkg::out_item_t expected_chars[$];
  itda_pkg::out_item_t char_due;
  int                  err_count = 0;
  bit                  tx_idle = 0;
  bit                  rx_idle = 0;
  int                  stall_left = 0;

  integer_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous upper bound on the whole run.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    err_count++;
  endtask

  // Mostly short pauses, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Append the decimal text of one number to the queue of expected characters.
  function automatic void predict_text(input itda_pkg::in_item_t item);
    int unsigned         bits;
    logic [63:0]         mask;
    logic [63:0]         mag;
    logic                neg;
    logic [7:0]          rev[MAX_CHARS];
    int                  nd;
    itda_pkg::out_item_t c;
    case (item.width_code)
      itda_pkg::WIDTH_8:  bits = 8;
      itda_pkg::WIDTH_16: bits = 16;
      itda_pkg::WIDTH_32: bits = 32;
      default:            bits = 64;
    endcase
    if (bits > VALUE_BITS) bits = VALUE_BITS;
    mask = (bits >= 64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
    mag  = item.value & mask;
    neg  = item.is_signed && mag[bits-1];
    if (neg) mag = (64'd0 - mag) & mask;
    nd = 0;
    do begin
      rev[nd] = itda_pkg::ASCII_ZERO + 8'(mag % 64'd10);
      mag = mag / 64'd10;
      nd++;
    end while (mag != 0 && nd < MAX_CHARS);
    if (neg && nd < MAX_CHARS) begin
      c.character = itda_pkg::ASCII_MINUS;
      c.last      = 1'b0;
      expected_chars.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.character = rev[k];
      c.last      = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // Present one number, hold it until accepted; valid stays up for a following beat.
  task automatic send_number(input logic [63:0] v, input logic [1:0] wc, input logic sg);
    int gap;
    gap = (tx_idle && $urandom_range(0, 99) < 30) ? gap_length() : 0;
    @(negedge clk);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_data.value      = v;
    in_data.width_code = wc;
    in_data.is_signed  = sg;
    do @(posedge clk); while (in_stall);
    predict_text(in_data);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] p;
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 20));
      2: begin
        p = 64'd1;
        repeat ($urandom_range(1, 19)) p = p * 64'd10;
        return p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      3: return {$urandom, $urandom} >> $urandom_range(0, 63);
      4: return {$urandom, $urandom} | (64'd1 << (8 * (1 << $urandom_range(0, 3)) - 1));
      default: return {64{1'b1}} ^ 64'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_random(input int count);
    repeat (count)
      send_number(random_value(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  // Drop valid so the last number is not taken twice, then wait for its text.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    tx_idle = 0;
    rx_idle = 0;
    send_number(64'd0, itda_pkg::WIDTH_8, 1'b0);
    send_number(64'd0, itda_pkg::WIDTH_64, 1'b1);
    send_number(64'd9, itda_pkg::WIDTH_16, 1'b0);
    send_number(64'd10, itda_pkg::WIDTH_32, 1'b1);
    send_number(64'd99, itda_pkg::WIDTH_8, 1'b1);
    send_number(64'd100, itda_pkg::WIDTH_8, 1'b0);
    send_number(64'hFF, itda_pkg::WIDTH_8, 1'b0);
    send_number(64'h7F, itda_pkg::WIDTH_8, 1'b1);
    send_number(64'h80, itda_pkg::WIDTH_8, 1'b1);
    send_number(64'hFFFF_FFFF_FFFF_FF05, itda_pkg::WIDTH_8, 1'b0);
    send_number(64'hFFFF, itda_pkg::WIDTH_16, 1'b0);
    send_number(64'hFFFF, itda_pkg::WIDTH_16, 1'b1);
    send_number(64'h8000, itda_pkg::WIDTH_16, 1'b1);
    send_number(64'hFFFF_FFFF, itda_pkg::WIDTH_32, 1'b0);
    send_number(64'h7FFF_FFFF, itda_pkg::WIDTH_32, 1'b1);
    send_number(64'h8000_0000, itda_pkg::WIDTH_32, 1'b1);
    send_number(64'hFFFF_FFFF_8000_0000, itda_pkg::WIDTH_32, 1'b0);
    send_number({64{1'b1}}, itda_pkg::WIDTH_64, 1'b0);
    send_number({64{1'b1}}, itda_pkg::WIDTH_64, 1'b1);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, itda_pkg::WIDTH_64, 1'b1);
    send_number(64'h8000_0000_0000_0000, itda_pkg::WIDTH_64, 1'b1);
    send_number(64'd10000000000000000000, itda_pkg::WIDTH_64, 1'b0);
    send_number(64'd9999999999999999999, itda_pkg::WIDTH_64, 1'b0);
  endtask

  task automatic test_back_to_back();
    tx_idle = 0;
    rx_idle = 0;
    send_random(100);
  endtask

  task automatic test_random_idle();
    tx_idle = 1;
    rx_idle = 1;
    send_random(230);
  endtask

  // Hold the sender off until all pending text has drained, every few numbers.
  task automatic test_drain_pause();
    tx_idle = 1;
    rx_idle = 1;
    repeat (6) begin
      send_random(10);
      wait_drained();
    end
  endtask

  // Output side: random stall stretches when idling is enabled.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && rx_idle && $urandom_range(0, 99) < 20)
        stall_left = gap_length();
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare each accepted character beat with the oldest expectation.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char=%0d last=%0b",
                                    out_data.character, out_data.last));
        end else begin
          char_due = expected_chars.pop_front();
          if (out_data.character !== char_due.character)
            report_mismatch($sformatf("character got %0d want %0d",
                                      out_data.character, char_due.character));
          if (out_data.last !== char_due.last)
            report_mismatch($sformatf("last got %0b want %0b (char %0d)",
                                      out_data.last, char_due.last, char_due.character));
        end
      end
    end
  end

  initial begin
    int waited;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_back_to_back();
    test_random_idle();
    test_drain_pause();

    @(negedge clk);
    in_valid = 1'b0;
    rx_idle  = 0;

    waited = 0;
    while (expected_chars.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_chars.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
    repeat (30) @(posedge clk);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
